### src/chd_pkg.sv
// chd_pkg: shared types, codes and the hex digit decoder for the chunked
// body decoder. Depends on nothing.
package chd_pkg;

  localparam int LEN_W = 32;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_SIZE_LF = 3'd1,
    PH_DATA    = 3'd2,
    PH_DATA_CR = 3'd3,
    PH_DATA_LF = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_PAYLOAD  = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_ERROR    = 2'd2
  } status_t;

  typedef struct packed {
    logic             valid;
    logic [7:0]       data;
    status_t          status;
    logic [LEN_W-1:0] length;
  } result_t;

  // bit 4 set when the byte is a hex digit, low nibble is its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

### src/chd_parser.sv
// chd_parser: chunk framing state and the one-byte step that updates it.
// Depends on chd_pkg.
module chd_parser
  import chd_pkg::*;
#(
  parameter int SIZE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] data,
  output result_t    res
);

  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] remaining, remaining_next;
  logic                 digit_seen, digit_seen_next;
  logic [LEN_W-1:0]     total_bytes, total_bytes_next;

  logic [4:0]           hex;
  logic                 size_ovf;
  logic [SIZE_BITS-1:0] remaining_dec;
  logic                 fail;

  assign hex           = hex_decode(data);
  assign size_ovf      = remaining[SIZE_BITS-1 -: 4] != 4'd0;
  assign remaining_dec = remaining - SIZE_BITS'(1);

  // next state
  always_comb begin
    phase_next       = phase;
    remaining_next   = remaining;
    digit_seen_next  = digit_seen;
    total_bytes_next = total_bytes;
    fail             = 1'b0;
    case (phase)
      PH_SIZE: begin
        if (hex[4]) begin
          if (size_ovf) begin
            fail = 1'b1;
          end else begin
            remaining_next  = {remaining[SIZE_BITS-5:0], hex[3:0]};
            digit_seen_next = 1'b1;
          end
        end else if (data == CHAR_CR && digit_seen) begin
          phase_next = PH_SIZE_LF;
        end else begin
          fail = 1'b1;
        end
      end
      PH_SIZE_LF: begin
        if (data != CHAR_LF || remaining == '0) begin
          fail = 1'b1;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        remaining_next = remaining_dec;
        if (total_bytes != '1) begin
          total_bytes_next = total_bytes + LEN_W'(1);
        end
        if (remaining_dec == '0) begin
          phase_next = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (data == CHAR_CR) begin
          phase_next = PH_DATA_LF;
        end else begin
          fail = 1'b1;
        end
      end
      PH_DATA_LF: begin
        if (data == CHAR_LF) begin
          phase_next      = PH_SIZE;
          remaining_next  = '0;
          digit_seen_next = 1'b0;
        end else begin
          fail = 1'b1;
        end
      end
      default: begin
        fail = 1'b1;
      end
    endcase
    if (fail) begin
      phase_next       = PH_SIZE;
      remaining_next   = '0;
      digit_seen_next  = 1'b0;
      total_bytes_next = '0;
    end
  end

  // result of this byte
  always_comb begin
    res.valid  = 1'b0;
    res.data   = 8'd0;
    res.status = ST_PAYLOAD;
    res.length = '0;
    case (phase)
      PH_SIZE: begin
        if ((hex[4] && size_ovf) || (!hex[4] && !(data == CHAR_CR && digit_seen))) begin
          res.valid  = 1'b1;
          res.status = ST_ERROR;
        end
      end
      PH_SIZE_LF: begin
        if (data != CHAR_LF) begin
          res.valid  = 1'b1;
          res.status = ST_ERROR;
        end else if (remaining == '0) begin
          res.valid  = 1'b1;
          res.status = ST_COMPLETE;
          res.length = total_bytes;
        end
      end
      PH_DATA: begin
        res.valid = 1'b1;
        res.data  = data;
      end
      PH_DATA_CR: begin
        if (data != CHAR_CR) begin
          res.valid  = 1'b1;
          res.status = ST_ERROR;
        end
      end
      PH_DATA_LF: begin
        if (data != CHAR_LF) begin
          res.valid  = 1'b1;
          res.status = ST_ERROR;
        end
      end
      default: begin
        res.valid  = 1'b1;
        res.status = ST_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SIZE;
      remaining   <= '0;
      digit_seen  <= 1'b0;
      total_bytes <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      remaining   <= remaining_next;
      digit_seen  <= digit_seen_next;
      total_bytes <= total_bytes_next;
    end
  end

endmodule

### src/chd_out_reg.sv
// chd_out_reg: result register on the output channel, holds a stalled request.
// Depends on chd_pkg.
module chd_out_reg
  import chd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  result_t          res,
  input  logic             out_stall,
  output logic             can_load,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic [1:0]       status,
  output logic [LEN_W-1:0] body_length
);

  logic             valid, valid_next;
  logic [7:0]       data;
  status_t          st;
  logic [LEN_W-1:0] length;

  assign can_load   = !valid || !out_stall;
  assign valid_next = load ? res.valid : (valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      data   <= res.data;
      st     <= res.status;
      length <= res.length;
    end
  end

  assign out_valid   = valid;
  assign out_byte    = data;
  assign status      = st;
  assign body_length = length;

endmodule

### src/http_chunked_body_decoder_core.sv
// http_chunked_body_decoder_core: top level of the chunked body decoder.
// Path: input register (accepted byte), parser step, result register (result request).
// Throughput: one byte per cycle while out_stall does not hold a full result register.
// Framing bytes give no result request, but for errors and the LF ending the zero-size chunk.
// Reset (rst, synchronous): clears the framing state and both valid flags.
// Depends on chd_pkg, chd_parser, chd_out_reg.
module http_chunked_body_decoder_core
  import chd_pkg::*;
#(
  parameter int SIZE_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic [1:0]       status,
  output logic [LEN_W-1:0] body_length
);

  logic       held_valid, held_valid_next;
  logic [7:0] held_byte;
  logic       can_load;
  logic       advance;
  logic       accept;
  result_t    res;

  assign advance         = held_valid && can_load;
  assign in_stall        = held_valid && !can_load;
  assign accept          = in_valid && !in_stall;
  assign held_valid_next = accept || (held_valid && !advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= in_byte;
    end
  end

  chd_parser #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .advance(advance),
    .data   (held_byte),
    .res    (res)
  );

  chd_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .res        (res),
    .out_stall  (out_stall),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .status     (status),
    .body_length(body_length)
  );

endmodule

### src/chd_checker.sv
// chd_checker: port-level checks of the chunked body decoder, bound to the top.
// Depends on chd_pkg and http_chunked_body_decoder_core.
module chd_checker
  import chd_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [7:0]       out_byte,
  input logic [1:0]       status,
  input logic [LEN_W-1:0] body_length
);

  // stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(status)
      && $stable(body_length))
    else $error("stalled result changed");

  // status code in range
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_PAYLOAD || status == ST_COMPLETE || status == ST_ERROR))
    else $error("bad status code");

  // unused fields read zero
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status == ST_PAYLOAD) ? (body_length == '0) : (out_byte == 8'd0))
      && (status == ST_COMPLETE || body_length == '0))
    else $error("unused result field not zero");

  // empty result register never holds off the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("valid after reset");

endmodule

bind http_chunked_body_decoder_core chd_checker u_chd_checker (.*);
